// ===== rtl/core/bdc_pkg.sv =====
// Shared types and constants for the button debounce and click detector.
// Holds the item structs, the configuration set and the register index codes.
package bdc_pkg;

  // Register index codes on the configuration port
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_ACTIVE_LEVEL    = 3'd0,
    REG_DEGLITCH_MS     = 3'd1,
    REG_DEBOUNCE_MS     = 3'd2,
    REG_LONG_PRESS_MS   = 3'd3,
    REG_DOUBLE_CLICK_MS = 3'd4
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic                   ActiveLevelReset   = 1'b0;
  localparam logic [CfgDataBits-1:0] DeglitchMsReset    = 16'd10;
  localparam logic [CfgDataBits-1:0] DebounceMsReset    = 16'd50;
  localparam logic [CfgDataBits-1:0] LongPressMsReset   = 16'd300;
  localparam logic [CfgDataBits-1:0] DoubleClickMsReset = 16'd250;

  typedef struct packed {
    logic                   active_level;
    logic [CfgDataBits-1:0] deglitch_ms;
    logic [CfgDataBits-1:0] debounce_ms;
    logic [CfgDataBits-1:0] long_press_ms;
    logic [CfgDataBits-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic switched;
    logic pushed;
    logic released;
    logic is_on;
    logic long_press;
    logic double_click;
    logic single_click;
  } out_item_t;

endpackage

// ===== rtl/core/button_debounce_click_detect.sv =====
// Top level of the button debounce and click detector: handshakes, config registers.
// Depends on bdc_pkg and instantiates bdc_eval.
//
//   channel | signals                        | payload
//   --------+--------------------------------+----------------------------
//   in      | in_valid / in_ready            | in_data  (pin_level, now_ms)
//   out     | out_valid / out_ready          | out_data (seven event flags)
//   config  | cfg_we, cfg_index, cfg_data    | five registers, no read-back
//
// One item per cycle unless the output stalls; each item passes the input then the result register.
// An item waits in the input register, is evaluated in one pass and lands in
// the result register; the input register refills in the same cycle.
// A stalled output holds the result register, and the input register fills then stalls.
// Synchronous reset clears the switch state and loads the register defaults.
module button_debounce_click_detect #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bdc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bdc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bdc_pkg::CfgIndexBits-1:0]    cfg_index,
  input  logic [bdc_pkg::CfgDataBits-1:0]     cfg_data
);
  import bdc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  out_item_t result;
  logic      advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level    <= ActiveLevelReset;
      cfg.deglitch_ms     <= DeglitchMsReset;
      cfg.debounce_ms     <= DebounceMsReset;
      cfg.long_press_ms   <= LongPressMsReset;
      cfg.double_click_ms <= DoubleClickMsReset;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_ACTIVE_LEVEL:    cfg.active_level    <= cfg_data[0];
        REG_DEGLITCH_MS:     cfg.deglitch_ms     <= cfg_data;
        REG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data;
        REG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data;
        REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held item when the result register is free or being drained
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  bdc_eval #(
    .TIME_BITS(TIME_BITS)
  ) u_eval (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/core/bdc_eval.sv =====
// Switch state and per-item evaluation: deglitch, debounce and click events.
// Depends on bdc_pkg for the item structs and the configuration set.
module bdc_eval #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bdc_pkg::in_item_t item,
  input  bdc_pkg::cfg_t     cfg,
  output bdc_pkg::out_item_t result
);
  import bdc_pkg::*;

  typedef logic [TIME_BITS-1:0] stamp_t;

  // Stored switch state
  logic   primed;
  logic   previous_level;
  logic   clean_level;
  logic   stable_level;
  stamp_t glitch_stamp;
  stamp_t change_stamp;
  stamp_t push_stamp;
  stamp_t release_stamp;
  logic   single_block;
  logic   long_block;

  logic   clean_level_next;
  logic   stable_level_next;
  stamp_t glitch_stamp_next;
  logic   single_block_next;
  logic   long_block_next;

  stamp_t now;
  logic   prev_eff;
  logic   clean_eff;
  logic   stable_eff;
  stamp_t change_eff;
  stamp_t d_glitch;
  stamp_t d_change;
  stamp_t d_push;
  stamp_t d_press;
  logic   sw;
  logic   on;
  logic   push;
  logic   rel;
  logic   in_window;
  logic   sb_mid;
  logic   lb_mid;
  logic   sc;
  logic   lp;

  // First item primes the levels and the change stamp from itself
  always_comb begin
    now        = TIME_BITS'(item.now_ms);
    prev_eff   = primed ? previous_level : item.pin_level;
    clean_eff  = primed ? clean_level    : item.pin_level;
    stable_eff = primed ? stable_level   : item.pin_level;
    change_eff = primed ? change_stamp   : now;
    d_glitch   = now - glitch_stamp;
    d_change   = now - change_eff;
    d_push     = now - push_stamp;
    d_press    = release_stamp - push_stamp;
  end

  // Deglitch: accept the pin level once it has held long enough
  always_comb begin
    clean_level_next  = clean_eff;
    glitch_stamp_next = glitch_stamp;
    if (item.pin_level != prev_eff) begin
      glitch_stamp_next = now;
    end else if (d_glitch > TIME_BITS'(cfg.deglitch_ms)) begin
      clean_level_next  = item.pin_level;
      glitch_stamp_next = now;
    end
  end

  // Debounce and level events
  always_comb begin
    sw = (clean_level_next != stable_eff) && (d_change > TIME_BITS'(cfg.debounce_ms));
    stable_level_next = sw ? clean_level_next : stable_eff;
    on   = (stable_level_next == cfg.active_level);
    push = sw && on;
    rel  = sw && !on;
  end

  // Click events, all measured from the previous push
  always_comb begin
    in_window = d_push < TIME_BITS'(cfg.double_click_ms);
    sb_mid    = push ? in_window : single_block;
    sc        = 1'b0;
    single_block_next = sb_mid;
    if (!sb_mid) begin
      sc = !sw && !on && (d_press <= TIME_BITS'(cfg.long_press_ms)) && !in_window;
      single_block_next = sc;
    end

    lb_mid = rel ? 1'b0 : long_block;
    lp     = 1'b0;
    long_block_next = lb_mid;
    if (!lb_mid) begin
      lp = !sw && on && (d_push > TIME_BITS'(cfg.long_press_ms));
      long_block_next = lp;
    end
  end

  always_comb begin
    result.switched     = sw;
    result.pushed       = push;
    result.released     = rel;
    result.is_on        = on;
    result.long_press   = lp;
    result.double_click = push && in_window;
    result.single_click = sc;
  end

  // Commit state when an item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      primed         <= 1'b0;
      previous_level <= 1'b0;
      clean_level    <= 1'b0;
      stable_level   <= 1'b0;
      glitch_stamp   <= '0;
      change_stamp   <= '0;
      push_stamp     <= '0;
      release_stamp  <= '0;
      single_block   <= 1'b1;
      long_block     <= 1'b0;
    end else if (fire) begin
      primed         <= 1'b1;
      previous_level <= item.pin_level;
      clean_level    <= clean_level_next;
      stable_level   <= stable_level_next;
      glitch_stamp   <= glitch_stamp_next;
      change_stamp   <= sw ? now : change_eff;
      if (push) begin
        push_stamp <= now;
      end
      if (rel) begin
        release_stamp <= now;
      end
      single_block   <= single_block_next;
      long_block     <= long_block_next;
    end
  end

endmodule
